// ----- hw/rtl/thermistor_adc_to_temperature_macros.svh -----
// assertion macros shared by the thermistor conversion checkers
`ifndef THERMISTOR_ADC_TO_TEMPERATURE_MACROS_SVH
`define THERMISTOR_ADC_TO_TEMPERATURE_MACROS_SVH

// antecedent on a clock edge implies the consequent property
`define TADC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("tadc implication check failed");

// expression must never hold outside reset
`define TADC_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("tadc forbidden condition seen");

`endif

// ----- hw/rtl/tadc_pkg.sv -----
// types, widths and resistance tables for the thermistor conversion pipeline
package tadc_pkg;

    localparam int ADC_W        = 12;
    localparam int TEMP_W       = 15;
    localparam int TABLE_POINTS = 25;
    localparam int SEG_COUNT    = TABLE_POINTS - 1;
    localparam int IDX_W        = $clog2(SEG_COUNT);

    // table entries and in-range resistance, tenths of an ohm
    localparam int RES_W  = 21;
    // full quotient of the divider equation
    localparam int QUOT_W = 29;
    localparam logic [QUOT_W-1:0] RES_DIVIDEND = 29'd409500000;
    localparam logic [QUOT_W-1:0] RES_OFFSET   = 29'd100000;

    // interpolation: span of a segment, offset quotient, numerator
    localparam int SPAN_W   = 19;
    localparam int OFF_W    = 9;
    localparam int NUM_W    = SPAN_W + OFF_W;
    localparam int SEG_STEP = 500;

    localparam logic signed [TEMP_W-1:0] TEMP_MIN = -15'sd2000;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 15'sd10000;

    // quotient bits resolved per pipeline stage in each divider
    localparam int DIV1_SPS    = 4;
    localparam int DIV2_SPS    = 2;
    localparam int DIV1_STAGES = (QUOT_W + DIV1_SPS - 1) / DIV1_SPS;
    localparam int DIV2_STAGES = (OFF_W + DIV2_SPS - 1) / DIV2_SPS;
    // five stages between the dividers, one output register
    localparam int LATENCY     = DIV1_STAGES + 5 + DIV2_STAGES + 1;

    // resistance at -20 C .. 100 C in 5 C steps
    localparam logic [RES_W-1:0] RES_TENTHS [TABLE_POINTS] = '{
        21'd1146600, 21'd845100, 21'd629270, 21'd470770, 21'd355630,
        21'd271190,  21'd208600, 21'd162040, 21'd126830, 21'd100000,
        21'd79420,   21'd63270,  21'd50740,  21'd41030,  21'd33360,
        21'd27240,   21'd22370,  21'd18460,  21'd15300,  21'd12750,
        21'd10680,   21'd8993,   21'd7607,   21'd6452,   21'd5494
    };

    // upper entry minus lower entry of each segment
    localparam logic [SPAN_W-1:0] SEG_SPAN [SEG_COUNT] = '{
        19'd301500, 19'd215830, 19'd158500, 19'd115140, 19'd84440,
        19'd62590,  19'd46560,  19'd35210,  19'd26830,  19'd20580,
        19'd16150,  19'd12530,  19'd9710,   19'd7670,   19'd6120,
        19'd4870,   19'd3910,   19'd3160,   19'd2550,   19'd2070,
        19'd1687,   19'd1386,   19'd1155,   19'd958
    };

    typedef struct packed {
        logic below;
        logic above;
    } range_flags_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        range_flags_t     flags;
    } seg_side_t;

endpackage

// ----- hw/rtl/tadc_div.sv -----
// pipelined restoring divider, a fixed number of quotient bits per stage
module tadc_div #(
    parameter int DW  = 12,
    parameter int QW  = 29,
    parameter int SPS = 4,
    parameter int SBW = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [DW-1:0]  in_divisor,
    input  logic [DW-1:0]  in_rem,
    input  logic [QW-1:0]  in_bits,
    input  logic [SBW-1:0] in_side,
    output logic           out_valid,
    output logic [QW-1:0]  out_quot,
    output logic [SBW-1:0] out_side
);

    localparam int NST = (QW + SPS - 1) / SPS;

    logic [NST-1:0] valid_reg;
    logic [NST-1:0] valid_next;
    logic [DW-1:0]  div_reg   [NST];
    logic [DW-1:0]  div_next  [NST];
    logic [DW-1:0]  rem_reg   [NST];
    logic [DW-1:0]  rem_next  [NST];
    logic [QW-1:0]  bits_reg  [NST];
    logic [QW-1:0]  bits_next [NST];
    logic [QW-1:0]  quot_reg  [NST];
    logic [QW-1:0]  quot_next [NST];
    logic [SBW-1:0] side_reg  [NST];
    logic [SBW-1:0] side_next [NST];

    // stage inputs: ports for the first stage, previous registers after
    logic [DW-1:0]  rem_cur  [NST];
    logic [QW-1:0]  bits_cur [NST];
    logic [QW-1:0]  quot_cur [NST];

    always_comb
    begin
        valid_next[0] = in_valid;
        div_next[0]   = in_divisor;
        side_next[0]  = in_side;
        rem_cur[0]    = in_rem;
        bits_cur[0]   = in_bits;
        quot_cur[0]   = '0;
        for (int st = 1; st < NST; st++)
        begin
            valid_next[st] = valid_reg[st-1];
            div_next[st]   = div_reg[st-1];
            side_next[st]  = side_reg[st-1];
            rem_cur[st]    = rem_reg[st-1];
            bits_cur[st]   = bits_reg[st-1];
            quot_cur[st]   = quot_reg[st-1];
        end
    end

    // shift one dividend bit into the remainder, subtract when it fits
    always_comb
    begin
        logic [DW:0] trial;
        trial = '0;
        for (int st = 0; st < NST; st++)
        begin
            rem_next[st]  = rem_cur[st];
            bits_next[st] = bits_cur[st];
            quot_next[st] = quot_cur[st];
            for (int k = 0; k < SPS; k++)
            begin
                if (st * SPS + k < QW)
                begin
                    trial         = {rem_next[st], bits_next[st][QW-1]};
                    bits_next[st] = bits_next[st] << 1;
                    if (trial >= {1'b0, div_next[st]})
                    begin
                        trial         = trial - {1'b0, div_next[st]};
                        quot_next[st] = {quot_next[st][QW-2:0], 1'b1};
                    end
                    else
                    begin
                        quot_next[st] = {quot_next[st][QW-2:0], 1'b0};
                    end
                    rem_next[st] = trial[DW-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        bits_reg <= bits_next;
        quot_reg <= quot_next;
        side_reg <= side_next;
    end

    assign out_valid = valid_reg[NST-1];
    assign out_quot  = quot_reg[NST-1];
    assign out_side  = side_reg[NST-1];

endmodule

// ----- hw/rtl/thermistor_adc_to_temperature.sv -----
// NTC thermistor reading to temperature, fully pipelined
//
// One 12-bit converter reading enters per clock: a request is taken on any
// edge with start high, and busy is never raised. Each request gives exactly
// one result, shown for a single cycle with done high; the receiver cannot
// hold it off and must capture it in that cycle. The pipeline is built
// around the two pipelined long dividers: the resistance divider resolves
// four of its 29 quotient bits per stage (8 stages), the interpolation divider
// two of its 9 bits per stage (5 stages), with five stages of table search
// and interpolation between them and one output register. A zero reading or
// a resistance at or above the -20 C entry returns -20.00 C with below_range
// set; a resistance at or below the 100 C entry returns 100.00 C with
// above_range set. Otherwise the result is linearly interpolated within the
// 5 C segment and rounded to the nearest hundredth, ties up.
module thermistor_adc_to_temperature import tadc_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [ADC_W-1:0]         adc_value,
    output logic                     busy,
    output logic                     done,
    output logic signed [TEMP_W-1:0] temp_centideg,
    output logic                     below_range,
    output logic                     above_range
);

    // the pipeline never stalls, so every request is taken
    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // resistance divider: 409500000 / adc, zero reading flagged up front
    range_flags_t        div1_side;
    logic                q_valid;
    logic [QUOT_W-1:0]   quot;
    range_flags_t        q_flags;

    assign div1_side.below = (adc_value == '0);
    assign div1_side.above = 1'b0;

    tadc_div #(
        .DW  (ADC_W),
        .QW  (QUOT_W),
        .SPS (DIV1_SPS),
        .SBW ($bits(range_flags_t))
    ) u_div_res (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .in_divisor (adc_value),
        .in_rem     ({ADC_W{1'b0}}),
        .in_bits    (RES_DIVIDEND),
        .in_side    (div1_side),
        .out_valid  (q_valid),
        .out_quot   (quot),
        .out_side   (q_flags)
    );

    // stage a: remove the reference resistor, floor at zero
    logic                a_valid_reg;
    logic [QUOT_W-1:0]   a_res_reg;
    logic [QUOT_W-1:0]   a_res_next;
    range_flags_t        a_flags_reg;

    assign a_res_next = (quot >= RES_OFFSET) ? (quot - RES_OFFSET) : '0;

    // stage b: compare against every table entry in parallel
    logic                   b_valid_reg;
    logic [RES_W-1:0]       b_res_reg;
    logic [TABLE_POINTS-1:0] b_lt_reg;
    logic [TABLE_POINTS-1:0] b_lt_next;
    range_flags_t           b_flags_reg;
    range_flags_t           b_flags_next;

    always_comb
    begin
        for (int j = 0; j < TABLE_POINTS; j++)
        begin
            b_lt_next[j] = (a_res_reg < QUOT_W'(RES_TENTHS[j]));
        end
        // cold end wins, so a zero reading never reports hot
        b_flags_next.below = a_flags_reg.below ||
                             (a_res_reg >= QUOT_W'(RES_TENTHS[0]));
        b_flags_next.above = !b_flags_next.below &&
                             (a_res_reg <= QUOT_W'(RES_TENTHS[TABLE_POINTS-1]));
    end

    // stage c: segment index from the thermometer code, table lookups
    // entries above the reading form a run from index 0; the segment is
    // the last entry still above it, or the first segment if none
    logic                c_valid_reg;
    logic [IDX_W-1:0]    c_idx_reg;
    logic [IDX_W-1:0]    c_idx_next;
    logic [RES_W-1:0]    c_top_reg;
    logic [SPAN_W-1:0]   c_span_reg;
    logic [RES_W-1:0]    c_res_reg;
    range_flags_t        c_flags_reg;

    always_comb
    begin
        c_idx_next = '0;
        for (int j = 1; j < SEG_COUNT; j++)
        begin
            if (b_lt_reg[j])
            begin
                c_idx_next = IDX_W'(j);
            end
        end
    end

    // stage d: distance below the segment's upper entry
    logic                d_valid_reg;
    logic [SPAN_W-1:0]   d_x_reg;
    logic [SPAN_W-1:0]   d_x_next;
    logic [RES_W-1:0]    d_diff;
    logic [SPAN_W-1:0]   d_span_reg;
    seg_side_t           d_side_reg;
    seg_side_t           d_side_next;

    // in range the reading is inside the segment, so the distance fits
    assign d_diff            = c_top_reg - c_res_reg;
    assign d_x_next          = d_diff[SPAN_W-1:0];
    assign d_side_next.idx   = c_idx_reg;
    assign d_side_next.flags = c_flags_reg;

    // stage e: rounding numerator, distance * 500 + span / 2
    logic                e_valid_reg;
    logic [NUM_W-1:0]    e_num_reg;
    logic [NUM_W-1:0]    e_num_next;
    logic [SPAN_W-1:0]   e_span_reg;
    seg_side_t           e_side_reg;

    assign e_num_next = NUM_W'(d_x_reg) * NUM_W'(SEG_STEP) + NUM_W'(d_span_reg >> 1);

    // offset divider: quotient is at most 500, so nine bits suffice and
    // the upper numerator bits start out below the span
    logic                o_valid;
    logic [OFF_W-1:0]    o_off;
    seg_side_t           o_side;

    tadc_div #(
        .DW  (SPAN_W),
        .QW  (OFF_W),
        .SPS (DIV2_SPS),
        .SBW ($bits(seg_side_t))
    ) u_div_off (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (e_valid_reg),
        .in_divisor (e_span_reg),
        .in_rem     (e_num_reg[NUM_W-1:OFF_W]),
        .in_bits    (e_num_reg[OFF_W-1:0]),
        .in_side    (e_side_reg),
        .out_valid  (o_valid),
        .out_quot   (o_off),
        .out_side   (o_side)
    );

    // output stage: segment base plus offset, or a clamped end point
    logic                     done_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic signed [TEMP_W-1:0] temp_next;
    logic signed [TEMP_W-1:0] seg_base;
    logic signed [TEMP_W-1:0] off_ext;
    logic                     below_reg;
    logic                     above_reg;

    assign seg_base = TEMP_W'(o_side.idx) * TEMP_W'(SEG_STEP);
    assign off_ext  = TEMP_W'(o_off);

    always_comb
    begin
        priority if (o_side.flags.below)
        begin
            temp_next = TEMP_MIN;
        end
        else if (o_side.flags.above)
        begin
            temp_next = TEMP_MAX;
        end
        else
        begin
            temp_next = TEMP_MIN + seg_base + off_ext;
        end
    end

    // valid bits of the middle stages and the done strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            a_valid_reg <= q_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            done_reg    <= o_valid;
        end
    end

    // payload moves every cycle; a bubble carries don't-care data
    always_ff @(posedge clk)
    begin
        a_res_reg   <= a_res_next;
        a_flags_reg <= q_flags;

        b_res_reg   <= a_res_reg[RES_W-1:0];
        b_lt_reg    <= b_lt_next;
        b_flags_reg <= b_flags_next;

        c_idx_reg   <= c_idx_next;
        c_top_reg   <= RES_TENTHS[c_idx_next];
        c_span_reg  <= SEG_SPAN[c_idx_next];
        c_res_reg   <= b_res_reg;
        c_flags_reg <= b_flags_reg;

        d_x_reg     <= d_x_next;
        d_span_reg  <= c_span_reg;
        d_side_reg  <= d_side_next;

        e_num_reg   <= e_num_next;
        e_span_reg  <= d_span_reg;
        e_side_reg  <= d_side_reg;

        temp_reg    <= temp_next;
        below_reg   <= o_side.flags.below;
        above_reg   <= o_side.flags.above;
    end

    assign done          = done_reg;
    assign temp_centideg = temp_reg;
    assign below_range   = below_reg;
    assign above_range   = above_reg;

endmodule

// ----- hw/rtl/tadc_checker.sv -----
// port-level checks for the thermistor conversion block, with bind
`include "thermistor_adc_to_temperature_macros.svh"

module tadc_checker import tadc_pkg::*; (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     start,
    input logic                     busy,
    input logic                     done,
    input logic signed [TEMP_W-1:0] temp_centideg,
    input logic                     below_range,
    input logic                     above_range
);

    // every request comes out after the fixed pipeline latency
    `TADC_ASSERT_IMPLIES(a_req_done, clk, rst_n, start && !busy, ##LATENCY done)

    // no result without a request at the matching earlier edge
    `TADC_ASSERT_IMPLIES(a_done_req, clk, rst_n, done, $past(start && !busy, LATENCY))

    // the two clamp flags exclude each other
    `TADC_ASSERT_NEVER(a_flags_excl, clk, rst_n, done && below_range && above_range)

    // results stay within the table's temperature span
    `TADC_ASSERT_IMPLIES(a_temp_span, clk, rst_n, done, temp_centideg >= TEMP_MIN && temp_centideg <= TEMP_MAX)

    // a cold clamp reports the cold end point
    `TADC_ASSERT_IMPLIES(a_clamp_low, clk, rst_n, done && below_range, temp_centideg == TEMP_MIN)

endmodule

bind thermistor_adc_to_temperature tadc_checker u_tadc_checker (.*);

// ----- tb/sv/tb_top.sv -----
// self-checking bench for the thermistor reading to temperature converter
`timescale 1ns / 1ps

module tb_top;
    import tadc_pkg::*;

    // expected outcome of one converter reading
    typedef struct {
        logic [ADC_W-1:0]         adc;
        logic signed [TEMP_W-1:0] temp;
        logic                     below;
        logic                     above;
    } temp_reading_t;

    // holds predicted temperatures in request order and checks each result
    class temperature_scoreboard;
        temp_reading_t pending_temps[$];
        int            failures;

        function new();
            failures = 0;
        endfunction

        // divider resistance, table search and rounded interpolation
        function temp_reading_t convert_reading(logic [ADC_W-1:0] adc);
            temp_reading_t    t;
            longint unsigned  quot;
            longint unsigned  res;
            longint unsigned  top;
            longint unsigned  bot;
            longint unsigned  span;
            longint unsigned  frac;
            longint           centi;
            bit               found;
            t.adc   = adc;
            t.temp  = '0;
            t.below = 1'b0;
            t.above = 1'b0;
            found   = 1'b0;
            if (adc == '0)
            begin
                t.temp  = TEMP_MIN;
                t.below = 1'b1;
            end
            else
            begin
                quot = longint'(RES_DIVIDEND) / longint'(adc);
                // resistance clamps at zero rather than wrapping
                res  = (quot >= longint'(RES_OFFSET)) ? quot - longint'(RES_OFFSET) : 0;
                if (res >= longint'(RES_TENTHS[0]))
                begin
                    t.temp  = TEMP_MIN;
                    t.below = 1'b1;
                end
                else if (res <= longint'(RES_TENTHS[TABLE_POINTS-1]))
                begin
                    t.temp  = TEMP_MAX;
                    t.above = 1'b1;
                end
                else
                begin
                    // first segment that brackets the resistance wins
                    for (int i = 0; i + 1 < TABLE_POINTS; i++)
                    begin
                        top = RES_TENTHS[i];
                        bot = RES_TENTHS[i+1];
                        if (!found && res <= top && res >= bot && top > bot)
                        begin
                            span   = top - bot;
                            frac   = ((top - res) * SEG_STEP + span / 2) / span;
                            centi  = longint'(TEMP_MIN) + SEG_STEP * i + longint'(frac);
                            t.temp = centi[TEMP_W-1:0];
                            found  = 1'b1;
                        end
                    end
                end
            end
            return t;
        endfunction

        function void note_request(logic [ADC_W-1:0] adc);
            pending_temps = {pending_temps, convert_reading(adc)};
        endfunction

        function void check_result(logic signed [TEMP_W-1:0] temp, logic below,
                                   logic above);
            temp_reading_t t;
            if (pending_temps.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0d / %0b / %0b",
                         $time, temp, below, above);
                failures++;
                return;
            end
            t = pending_temps.pop_front();
            if (temp !== t.temp)
            begin
                $display("%0t: adc %0d temp_centideg expected %0d actual %0d",
                         $time, t.adc, t.temp, temp);
                failures++;
            end
            if (below !== t.below)
            begin
                $display("%0t: adc %0d below_range expected %0b actual %0b",
                         $time, t.adc, t.below, below);
                failures++;
            end
            if (above !== t.above)
            begin
                $display("%0t: adc %0d above_range expected %0b actual %0b",
                         $time, t.adc, t.above, above);
                failures++;
            end
        endfunction

        function int outstanding();
            return pending_temps.size();
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic [ADC_W-1:0]         adc_value;
    logic                     busy;
    logic                     done;
    logic signed [TEMP_W-1:0] temp_centideg;
    logic                     below_range;
    logic                     above_range;

    temperature_scoreboard sb;
    // when set, requests go back to back with no gaps
    bit                    no_gaps;

    thermistor_adc_to_temperature dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .adc_value     (adc_value),
        .busy          (busy),
        .done          (done),
        .temp_centideg (temp_centideg),
        .below_range   (below_range),
        .above_range   (above_range)
    );

    // 12 ns clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // every input is driven before any edge; the scoreboard exists before the monitor runs
    initial
    begin
        sb        = new();
        rst_n     = 1'b0;
        start     = 1'b0;
        adc_value = '0;
        no_gaps   = 1'b0;
    end

    // monitor: all signals change by nonblocking updates, so values read here are pre-edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_request(adc_value);
            if (done)
                sb.check_result(temp_centideg, below_range, above_range);
        end
    end

    // one request: optional random gap, then hold start until accepted
    task automatic send_reading(input logic [ADC_W-1:0] adc);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        adc_value <= adc;
        // busy read just after the edge is the value the edge saw
        do
            @(posedge clk);
        while (busy);
    endtask

    // pick a reading, weighted toward the interpolated range and the clamp edges
    function automatic logic [ADC_W-1:0] pick_reading();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            return ADC_W'($urandom_range(329, 3881));
        else if (sel < 78)
            return ADC_W'($urandom_range(0, 340));
        else if (sel < 86)
            return ADC_W'($urandom_range(3870, 4095));
        else
            return ADC_W'($urandom());
    endfunction

    // directed readings: zero, clamp boundaries, full scale, bit patterns
    localparam int DIRECTED_COUNT = 23;
    localparam logic [ADC_W-1:0] DIRECTED_READINGS [DIRECTED_COUNT] = '{
        12'd0,    12'd1,    12'd2,    12'd327,  12'd328,  12'd329,
        12'd330,  12'd500,  12'd1000, 12'd2047, 12'd2048, 12'd3000,
        12'd3880, 12'd3881, 12'd3882, 12'd3883, 12'd4094, 12'd4095,
        12'haaa,  12'h555,  12'h800,  12'h7ff,  12'd1
    };

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, back to back first so the pipeline fills
        no_gaps = 1'b1;
        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            if (i == 12)
                no_gaps = 1'b0;
            send_reading(DIRECTED_READINGS[i]);
        end

        // random part, switching between gapped and gapless stretches
        for (int n = 0; n < 1250; n++)
        begin
            if ($urandom_range(0, 39) == 0)
                no_gaps = ~no_gaps;
            send_reading(pick_reading());
        end
        start <= 1'b0;

        // drain the pipeline, then keep watching for stray results
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);

        if (sb.failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
